/* rtl/stereo_dual_comb_texture_delay_unit_defines.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the stereo dual-comb texture delay unit.
// ----------------------------------------------------------------------------
`ifndef STEREO_DUAL_COMB_TEXTURE_DELAY_UNIT_DEFINES_SVH
`define STEREO_DUAL_COMB_TEXTURE_DELAY_UNIT_DEFINES_SVH

// Implication checked on every edge outside reset.
`define SDC_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Implication checked in the cycle after the antecedent.
`define SDC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/sdctd_pkg.sv */
// ----------------------------------------------------------------------------
// sdctd_pkg
// Shared types and constants for the stereo dual-comb texture delay.
// ----------------------------------------------------------------------------
`default_nettype none
package sdctd_pkg;

  localparam logic [1:0] CFG_VOICING   = 2'd0;
  localparam logic [1:0] CFG_INTENSITY = 2'd1;
  localparam logic [1:0] CFG_RATE      = 2'd2;

  localparam logic [31:0] SLIDE_K     = 32'd1288490;
  localparam logic [31:0] SLIDE_RESET = 32'd1808181232;
  localparam logic [15:0] VOICING_RST = 16'd27591;
  localparam logic [16:0] INTENS_RST  = 17'd32768;
  localparam logic [10:0] RATE_RST    = 11'd256;

  // Tap selectors for the datapath.
  localparam logic [2:0] TAP_A0 = 3'd0;
  localparam logic [2:0] TAP_A1 = 3'd1;
  localparam logic [2:0] TAP_A2 = 3'd2;
  localparam logic [2:0] TAP_B0 = 3'd3;
  localparam logic [2:0] TAP_B1 = 3'd4;
  localparam logic [2:0] TAP_B2 = 3'd5;

  // Commands from controller to datapath.
  typedef struct packed {
    logic       load;      // seed accumulators, start slide update
    logic       calc;      // advance offset pipeline (one step)
    logic [2:0] calc_step; // which offset step
    logic       wr;        // write ring
    logic       rd;        // issue a tap read
    logic [2:0] rd_tap;
    logic       acc;       // accumulate returned tap
    logic [2:0] acc_tap;
    logic       mix;       // wet/dry mix step
    logic [1:0] mix_step;
    logic       finish;    // result to output register, move pointer
  } sdctd_cmd_t;

endpackage
`default_nettype wire

/* rtl/sdctd_ram.sv */
// ----------------------------------------------------------------------------
// sdctd_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none
module sdctd_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 2048
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

/* rtl/sdctd_ctrl.sv */
// ----------------------------------------------------------------------------
// sdctd_ctrl
// Sequencer: clearing pass, then per-item command schedule.
// ----------------------------------------------------------------------------
`default_nettype none
module sdctd_ctrl
  import sdctd_pkg::*;
#(
  parameter int RING_DEPTH = 2048
) (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  in_valid,
  output logic       in_ready,
  output logic       out_valid,
  input  wire logic  out_ready,
  output logic       clearing,
  output logic [$clog2(RING_DEPTH)-1:0] clr_addr,
  output sdctd_cmd_t cmd
);
  localparam int AW = $clog2(RING_DEPTH);
  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_RUN   = 2'd2;

  logic [1:0] state;
  logic [4:0] step;
  logic [AW:0] clr_cnt;
  logic out_free;
  logic hold;
  logic out_valid_next;

  // A new item is taken whenever the sequencer is idle. The finish step
  // waits until the output register is free.
  assign in_ready = (state == ST_IDLE);
  assign clearing = (state == ST_CLEAR);
  assign clr_addr = clr_cnt[AW-1:0];
  assign out_free = !out_valid || out_ready;
  assign hold     = (state == ST_RUN) && (step == 5'd18) && !out_free;

  // Schedule: 0 load; 1..5 offset steps; 6 write; 7..12 reads;
  // 9..14 accumulate (read through the RAM and rd_l registers); 15..17 mix; 18 finish.
  always_comb begin
    cmd = '0;
    if (state == ST_RUN) begin
      if (step == 5'd0) cmd.load = 1'b1;
      if (step >= 5'd1 && step <= 5'd5) begin
        cmd.calc = 1'b1;
        cmd.calc_step = 3'(step - 5'd1);
      end
      if (step == 5'd6) cmd.wr = 1'b1;
      if (step >= 5'd7 && step <= 5'd12) begin
        cmd.rd = 1'b1;
        cmd.rd_tap = 3'(step - 5'd7);
      end
      if (step >= 5'd9 && step <= 5'd14) begin
        cmd.acc = 1'b1;
        cmd.acc_tap = 3'(step - 5'd9);
      end
      if (step >= 5'd15 && step <= 5'd17) begin
        cmd.mix = 1'b1;
        cmd.mix_step = 2'(step - 5'd15);
      end
      if (step == 5'd18) cmd.finish = out_free;
    end
  end

  always_comb begin
    out_valid_next = out_valid;
    if (out_valid && out_ready) out_valid_next = 1'b0;
    if (cmd.finish) out_valid_next = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      step      <= '0;
      clr_cnt   <= '0;
      out_valid <= 1'b0;
    end else begin
      out_valid <= out_valid_next;
      case (state)
        ST_CLEAR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (clr_cnt == (AW+1)'(RING_DEPTH - 1)) state <= ST_IDLE;
        end
        ST_IDLE: begin
          if (in_valid && in_ready) begin
            state <= ST_RUN;
            step  <= '0;
          end
        end
        ST_RUN: begin
          if (!hold) begin
            step <= step + 1'b1;
            if (step == 5'd18) state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

/* rtl/sdctd_datapath.sv */
// ----------------------------------------------------------------------------
// sdctd_datapath
// Slide filter, tap offsets, delay rings, tap accumulation and mix.
// ----------------------------------------------------------------------------
`default_nettype none
module sdctd_datapath
  import sdctd_pkg::*;
#(
  parameter int RING_DEPTH  = 2048,
  parameter int SAMPLE_BITS = 24
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  sdctd_cmd_t                         cmd,
  input  wire logic                          clearing,
  input  wire logic [$clog2(RING_DEPTH)-1:0] clr_addr,
  input  wire logic                          in_take,
  input  wire logic signed [SAMPLE_BITS-1:0] left_in,
  input  wire logic signed [SAMPLE_BITS-1:0] right_in,
  input  wire logic [15:0]                   voicing,
  input  wire logic [16:0]                   intensity,
  input  wire logic [10:0]                   rate_scale,
  output logic signed [SAMPLE_BITS-1:0]      left_out,
  output logic signed [SAMPLE_BITS-1:0]      right_out
);
  localparam int AW = $clog2(RING_DEPTH);
  localparam int SB = SAMPLE_BITS;
  localparam int AB = SB + 20; // accumulator width
  localparam int MB = AB + 18; // mix width
  localparam logic [31:0] DIV5_M   = 32'd858993460; // ceil(2^32/5)
  localparam logic [21:0] FRAC77_M = 22'd126203;    // 77*ceil(2^15/20)

  logic signed [SB-1:0] xl, xr;
  logic [31:0] slide;
  logic [63:0] prod_a, prod_b;
  logic [31:0] off_a;
  logic [39:0] off_b;
  logic [27:0] q20;
  logic [4:0]  r20;
  logic [34:0] q77;
  logic [6:0]  frac77;
  logic [63:0] offb_scaled;
  logic [AW-1:0] d_a, d_b, w_a, w_b;
  logic [AW-1:0] wpos;
  logic [AW-1:0] raddr;
  logic signed [SB-1:0] rd_l, rd_r;
  logic signed [AB-1:0] acc_l, acc_r;
  logic signed [MB-1:0] mix_l, mix_r;
  logic [16:0] wf;
  logic [10:0] w_b_full;

  // Slide filter: two 32x32 products, registered.
  always_ff @(posedge clk) begin
    if (rst) begin
      slide <= SLIDE_RESET;
    end else if (cmd.calc && cmd.calc_step == 3'd0) begin
      slide <= slide - prod_a[63:32] + prod_b[63:32];
    end
  end

  assign w_b_full = 11'((14'(rate_scale) * 14'd7) >> 8);

  always_ff @(posedge clk) begin
    if (in_take) begin
      xl <= left_in;
      xr <= right_in;
    end
    if (cmd.load) begin
      prod_a <= 64'(slide) * 64'(SLIDE_K);
      prod_b <= 64'({voicing, 16'd0}) * 64'(SLIDE_K);
      wf     <= (intensity > 17'd65536) ? 17'd65536 : intensity;
    end
    if (cmd.calc) begin
      case (cmd.calc_step)
        3'd1: begin
          prod_a <= 64'(slide[31:8]) * 64'(slide[31:8]);
        end
        3'd2: off_a <= 32'(prod_a[47:24]) * 32'd77 + 32'd53687091;
        3'd3: begin
          // offB = 77*q + floor(77*r/20) + 41<<24, with offA = 20*q + r.
          q20    <= 28'((64'(off_a[31:2]) * 64'(DIV5_M)) >> 32);
          prod_a <= 64'(off_a) * 64'(rate_scale);
        end
        3'd4: begin
          d_a <= AW'(prod_a >> 32);
          r20 <= 5'(off_a - 32'(q20) * 32'd20);
          q77 <= 35'(q20) * 35'd77;
          w_a <= AW'(rate_scale >> 8);
          w_b <= AW'(w_b_full);
        end
        default: begin
          d_a <= d_a;
        end
      endcase
    end
  end

  // The B offset is finished during the write step and scaled during the
  // first tap read, well before the first B tap is addressed.
  assign frac77      = 7'((22'(r20) * FRAC77_M) >> 15);
  assign offb_scaled = 64'(off_b) * 64'(rate_scale);

  always_ff @(posedge clk) begin
    if (cmd.wr) begin
      off_b <= 40'(q77) + 40'(frac77) + (40'd41 << 24);
    end
    if (cmd.rd && cmd.rd_tap == TAP_A0) begin
      d_b <= AW'(offb_scaled >> 32);
    end
  end

  // Tap address.
  always_comb begin
    case (cmd.rd_tap)
      TAP_A0:  raddr = wpos + d_a;
      TAP_A1:  raddr = wpos + d_a + w_a;
      TAP_A2:  raddr = wpos + d_a + (w_a << 1);
      TAP_B0:  raddr = wpos + d_b;
      TAP_B1:  raddr = wpos + d_b + w_b;
      TAP_B2:  raddr = wpos + d_b + (w_b << 1);
      default: raddr = wpos;
    endcase
  end

  logic              ram_we;
  logic [AW-1:0]     ram_wa;
  logic [SB-1:0]     ram_wl, ram_wr;
  assign ram_we = clearing || cmd.wr;
  assign ram_wa = clearing ? clr_addr : wpos;
  assign ram_wl = clearing ? '0 : xl;
  assign ram_wr = clearing ? '0 : xr;

  logic [SB-1:0] q_l, q_r;
  sdctd_ram #(.WIDTH(SB), .DEPTH(RING_DEPTH)) u_ram_l (
    .clk, .we(ram_we), .waddr(ram_wa), .wdata(ram_wl), .raddr, .rdata(q_l));
  sdctd_ram #(.WIDTH(SB), .DEPTH(RING_DEPTH)) u_ram_r (
    .clk, .we(ram_we), .waddr(ram_wa), .wdata(ram_wr), .raddr, .rdata(q_r));

  always_ff @(posedge clk) begin
    rd_l <= q_l;
    rd_r <= q_r;
  end

  logic signed [17:0] wt;
  always_comb begin
    case (cmd.acc_tap)
      TAP_A0, TAP_A2: wt = 18'sd7021;
      TAP_A1:         wt = 18'sd17957;
      TAP_B0, TAP_B2: wt = -18'sd37842;
      TAP_B1:         wt = -18'sd41222;
      default:        wt = 18'sd0;
    endcase
  end

  logic signed [SB+17:0] dry_l, dry_r;
  logic signed [AB-1:0]  wet_l, wet_r;
  assign wet_l = acc_l >>> 18;
  assign wet_r = acc_r >>> 18;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      acc_l <= AB'(xl) <<< 16;
      acc_r <= AB'(xr) <<< 16;
    end else if (cmd.acc) begin
      acc_l <= acc_l + AB'(rd_l) * AB'(wt);
      acc_r <= acc_r + AB'(rd_r) * AB'(wt);
    end
    if (cmd.mix) begin
      case (cmd.mix_step)
        2'd0: begin
          mix_l <= MB'(wet_l) * MB'($signed({1'b0, wf}));
          mix_r <= MB'(wet_r) * MB'($signed({1'b0, wf}));
        end
        2'd1: begin
          dry_l <= xl * $signed(18'(18'd65536 - 18'(wf)));
          dry_r <= xr * $signed(18'(18'd65536 - 18'(wf)));
        end
        default: begin
          mix_l <= mix_l + MB'(dry_l);
          mix_r <= mix_r + MB'(dry_r);
        end
      endcase
    end
  end

  localparam logic signed [MB-1:0] SMAX = MB'((64'sd1 <<< (SB-1)) - 1);
  localparam logic signed [MB-1:0] SMIN = -SMAX - 1;
  logic signed [MB-1:0] sh_l, sh_r;
  assign sh_l = mix_l >>> 16;
  assign sh_r = mix_r >>> 16;

  always_ff @(posedge clk) begin
    if (rst) begin
      wpos <= '0;
    end else if (cmd.finish) begin
      wpos <= wpos - 1'b1;
    end
    if (cmd.finish) begin
      left_out  <= (sh_l > SMAX) ? SMAX[SB-1:0] : (sh_l < SMIN) ? SMIN[SB-1:0] : sh_l[SB-1:0];
      right_out <= (sh_r > SMAX) ? SMAX[SB-1:0] : (sh_r < SMIN) ? SMIN[SB-1:0] : sh_r[SB-1:0];
    end
  end
endmodule
`default_nettype wire

/* rtl/stereo_dual_comb_texture_delay_unit.sv */
// ----------------------------------------------------------------------------
// stereo_dual_comb_texture_delay_unit
// Stereo dual-comb texture delay with configuration registers.
// ----------------------------------------------------------------------------
// Channel | Signals                               | Direction
// in      | in_valid in_ready left_in right_in    | sink
// out     | out_valid out_ready left_out right_out| source
// cfg     | cfg_valid cfg_ready cfg_index cfg_data| sink
//
// Each transaction runs the slide filter, offset multiplies and six
// registered reads from each ring on a schedule kept by the controller. A
// new transaction is not taken until the previous one has passed its
// finish step. A result that waits on out_ready holds the finish step of
// the next transaction, and with it the input. After reset the rings are
// cleared, one entry a cycle; inputs are not taken meanwhile, but
// configuration writes are.
// ----------------------------------------------------------------------------
`default_nettype none
module stereo_dual_comb_texture_delay_unit
  import sdctd_pkg::*;
#(
  parameter int RING_DEPTH  = 2048,
  parameter int SAMPLE_BITS = 24
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic signed [SAMPLE_BITS-1:0] left_in,
  input  wire logic signed [SAMPLE_BITS-1:0] right_in,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic signed [SAMPLE_BITS-1:0]      left_out,
  output logic signed [SAMPLE_BITS-1:0]      right_out,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [1:0]                    cfg_index,
  input  wire logic [16:0]                   cfg_data
);
  logic [15:0] voicing;
  logic [16:0] intensity;
  logic [10:0] rate_scale;
  sdctd_cmd_t cmd;
  logic clearing;
  logic [$clog2(RING_DEPTH)-1:0] clr_addr;

  // Configuration writes are always taken.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      voicing    <= VOICING_RST;
      intensity  <= INTENS_RST;
      rate_scale <= RATE_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_VOICING:   voicing    <= cfg_data[15:0];
        CFG_INTENSITY: intensity  <= cfg_data;
        CFG_RATE:      rate_scale <= cfg_data[10:0];
        default:       voicing    <= voicing;
      endcase
    end
  end

  sdctd_ctrl #(.RING_DEPTH(RING_DEPTH)) u_ctrl (
    .clk, .rst, .in_valid, .in_ready, .out_valid, .out_ready,
    .clearing, .clr_addr, .cmd);

  sdctd_datapath #(.RING_DEPTH(RING_DEPTH), .SAMPLE_BITS(SAMPLE_BITS)) u_dp (
    .clk, .rst, .cmd, .clearing, .clr_addr,
    .in_take(in_valid && in_ready), .left_in, .right_in,
    .voicing, .intensity, .rate_scale, .left_out, .right_out);
endmodule
`default_nettype wire

/* rtl/sdctd_checker.sv */
// ----------------------------------------------------------------------------
// sdctd_checker
// Port-level checks for the texture delay unit.
// ----------------------------------------------------------------------------
`default_nettype none
`include "stereo_dual_comb_texture_delay_unit_defines.svh"
module sdctd_checker #(
  parameter int SAMPLE_BITS = 24
) (
  input wire logic                   clk,
  input wire logic                   rst,
  input wire logic                   in_valid,
  input wire logic                   in_ready,
  input wire logic                   out_valid,
  input wire logic                   out_ready,
  input wire logic [SAMPLE_BITS-1:0] left_out,
  input wire logic [SAMPLE_BITS-1:0] right_out
);
  `SDC_ASSERT_NEXT(a_busy_after_take, in_valid && in_ready, !in_ready, "ready after acceptance")
  `SDC_ASSERT_NEXT(a_out_holds, out_valid && !out_ready, out_valid, "result dropped")
  `SDC_ASSERT_NEXT(a_out_stable, out_valid && !out_ready, $stable(left_out) && $stable(right_out), "result changed while waiting")
endmodule

bind stereo_dual_comb_texture_delay_unit sdctd_checker #(.SAMPLE_BITS(SAMPLE_BITS)) u_chk (
  .clk, .rst, .in_valid, .in_ready, .out_valid, .out_ready, .left_out, .right_out);
`default_nettype wire
